// File: rtl/circular_fifo_with_search_defines.svh
// Assertion macros shared by the RTL of the circular FIFO with search.
`ifndef CIRCULAR_FIFO_WITH_SEARCH_DEFINES_SVH
`define CIRCULAR_FIFO_WITH_SEARCH_DEFINES_SVH

`ifndef SYNTH
// Check a property on every rising clock edge outside reset.
`define CFWS_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");
// Check that a condition never holds outside reset.
`define CFWS_ASSERT_NEVER(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("forbidden condition seen");
`else
`define CFWS_ASSERT(label, clk, rst, prop)
`define CFWS_ASSERT_NEVER(label, clk, rst, expr)
`endif

`endif

// File: rtl/cfws_pkg.sv
package cfws_pkg;

   localparam int DEPTH   = 16;
   localparam int IDX_W   = $clog2(DEPTH);
   localparam int CNT_W   = 5;
   localparam int WORD_W  = 32;
   localparam int CAP_LIM = (DEPTH < 16) ? DEPTH : 16;

   typedef logic [IDX_W-1:0]         idx_type;
   typedef logic [CNT_W-1:0]         cnt_type;
   typedef logic signed [WORD_W-1:0] word_type;

   localparam cnt_type CAP_MAX = cnt_type'(CAP_LIM);

   typedef enum logic [2:0] {
      ACT_ENQUEUE    = 3'd0,
      ACT_DEQUEUE    = 3'd1,
      ACT_SEARCH     = 3'd2,
      ACT_PEEK_FRONT = 3'd3,
      ACT_PEEK_REAR  = 3'd4
   } action_type;

   typedef enum logic [1:0] {
      STS_OK        = 2'd0,
      STS_FULL      = 2'd1,
      STS_EMPTY     = 2'd2,
      STS_NOT_FOUND = 2'd3
   } status_type;

   // Per-cell control: load takes the shared word, shift takes the
   // neighbor's entry, compare tags the entry against the shared word.
   typedef struct packed {
      logic load;
      logic shift;
      logic compare;
   } cell_ctl_type;

endpackage

// File: rtl/cfws_cell.sv
module cfws_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  cfws_pkg::cell_ctl_type ctl_i,
   input  cfws_pkg::word_type     next_data_i,
   input  logic                   next_match_i,
   input  cfws_pkg::word_type     word_i,
   input  logic                   in_range_i,
   output cfws_pkg::word_type     data_o,
   output logic                   match_o
);

   cfws_pkg::word_type data_ff, data_in;
   logic               match_ff, match_in;

   always_comb begin
      data_in  = data_ff;
      match_in = match_ff;
      if (ctl_i.load) begin
         data_in = word_i;
      end else if (ctl_i.shift) begin
         data_in  = next_data_i;
         match_in = next_match_i;
      end else if (ctl_i.compare) begin
         match_in = in_range_i && (data_ff == word_i);
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
      if (reset) begin
         match_ff <= 1'b0;
      end else begin
         match_ff <= match_in;
      end
   end

   assign data_o  = data_ff;
   assign match_o = match_ff;

endmodule

// File: rtl/cfws_chain.sv
module cfws_chain (
   input  logic                   clock,
   input  logic                   reset,
   input  cfws_pkg::cell_ctl_type ctl_i,
   input  cfws_pkg::cnt_type      count_i,
   input  cfws_pkg::word_type     word_i,
   output cfws_pkg::word_type     front_data_o,
   output cfws_pkg::word_type     rear_data_o,
   output logic                   front_match_o,
   output logic                   more_match_o,
   output logic                   any_match_o
);

   cfws_pkg::word_type               data_q [cfws_pkg::DEPTH];
   logic [cfws_pkg::DEPTH-1:0]       match_q;
   cfws_pkg::idx_type                load_index;
   cfws_pkg::idx_type                rear_index;

   assign load_index = cfws_pkg::idx_type'(count_i);
   assign rear_index = cfws_pkg::idx_type'(count_i - cfws_pkg::cnt_type'(1));

   // Cell 0 holds the front; shifting moves every entry one cell forward
   // and wraps the front entry around to the last cell.
   for (genvar i = 0; i < cfws_pkg::DEPTH; i++) begin : g_cell
      cfws_pkg::cell_ctl_type ctl;
      cfws_pkg::word_type     next_data;
      logic                   next_match;
      logic                   in_range;

      assign ctl.load    = ctl_i.load && (cfws_pkg::idx_type'(i) == load_index);
      assign ctl.shift   = ctl_i.shift;
      assign ctl.compare = ctl_i.compare;
      assign in_range    = (32'(i) < 32'(count_i));

      if (i == cfws_pkg::DEPTH - 1) begin : g_tail
         assign next_data  = data_q[0];
         assign next_match = 1'b0;
      end else begin : g_body
         assign next_data  = data_q[i+1];
         assign next_match = match_q[i+1];
      end

      cfws_cell u_cell (
         .clock        (clock),
         .reset        (reset),
         .ctl_i        (ctl),
         .next_data_i  (next_data),
         .next_match_i (next_match),
         .word_i       (word_i),
         .in_range_i   (in_range),
         .data_o       (data_q[i]),
         .match_o      (match_q[i])
      );
   end

   assign front_data_o  = data_q[0];
   assign rear_data_o   = data_q[rear_index];
   assign front_match_o = match_q[0];
   assign more_match_o  = |match_q[cfws_pkg::DEPTH-1:1];
   assign any_match_o   = |match_q;

endmodule

// File: rtl/circular_fifo_with_search.sv
// Enqueue, dequeue, peek and unknown actions: busy stays low, the result
// beat is registered and shows in the cycle after accept, and a new item may start every cycle.
// Search on a non-empty FIFO: busy through a compare state, then DEPTH rotation
// steps of the cell chain, one beat per match (one not-found beat if none).
// The full rotation of the DEPTH-cell chain sets the search time.
// Reset (synchronous, active high): FIFO empty, capacity 16, store undefined.
`include "circular_fifo_with_search_defines.svh"

module circular_fifo_with_search (
   input  logic                        clock,
   input  logic                        reset,
   // input channel
   input  logic                        start,
   output logic                        busy,
   input  logic [2:0]                  req_action,
   input  logic signed [31:0]          req_value,
   // result channel
   output logic                        rsp_valid,
   output logic [1:0]                  rsp_status,
   output logic signed [31:0]          rsp_data,
   output logic [4:0]                  rsp_position,
   output logic                        rsp_is_empty,
   output logic                        rsp_is_full,
   output logic                        rsp_last,
   // configuration
   input  logic                        csr_we,
   input  logic [4:0]                  csr_wdata
);

   typedef enum logic [2:0] {
      ST_IDLE    = 3'b001,
      ST_COMPARE = 3'b010,
      ST_SCAN    = 3'b100
   } state_type;

   localparam cfws_pkg::idx_type LAST_STEP = cfws_pkg::idx_type'(cfws_pkg::DEPTH - 1);

   state_type                state_ff, state_in;
   cfws_pkg::cnt_type        cap_ff, cap_in;
   cfws_pkg::cnt_type        count_ff, count_in;
   cfws_pkg::word_type       key_ff, key_in;
   cfws_pkg::idx_type        step_ff, step_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   cfws_pkg::status_type     rsp_status_ff, rsp_status_in;
   cfws_pkg::word_type       rsp_data_ff, rsp_data_in;
   cfws_pkg::cnt_type        rsp_position_ff, rsp_position_in;
   logic                     rsp_is_empty_ff, rsp_is_empty_in;
   logic                     rsp_is_full_ff, rsp_is_full_in;
   logic                     rsp_last_ff, rsp_last_in;

   logic                     accept;
   cfws_pkg::cell_ctl_type   chain_ctl;
   cfws_pkg::word_type       chain_word;
   cfws_pkg::word_type       front_data;
   cfws_pkg::word_type       rear_data;
   logic                     front_match;
   logic                     more_match;
   logic                     any_match;
   logic                     is_empty_now;
   logic                     is_full_now;

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;

   // The shared word loads on enqueue and carries the key while comparing.
   assign chain_word = (state_ff == ST_COMPARE) ? key_ff : req_value;

   assign is_empty_now = (count_ff == '0);
   assign is_full_now  = (count_ff == cap_ff);

   // Saturate the capacity into 1 .. CAP_MAX.
   always_comb begin
      cap_in = cap_ff;
      if (csr_we) begin
         if (csr_wdata == '0) begin
            cap_in = cfws_pkg::cnt_type'(1);
         end else if (csr_wdata > cfws_pkg::CAP_MAX) begin
            cap_in = cfws_pkg::CAP_MAX;
         end else begin
            cap_in = csr_wdata;
         end
      end
   end

   always_comb begin
      state_in        = state_ff;
      count_in        = count_ff;
      key_in          = key_ff;
      step_in         = step_ff;
      chain_ctl       = '0;
      rsp_valid_in    = 1'b0;
      rsp_status_in   = cfws_pkg::STS_OK;
      rsp_data_in     = '0;
      rsp_position_in = '0;
      rsp_last_in     = 1'b1;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               rsp_valid_in = 1'b1;
               case (req_action)
                  cfws_pkg::ACT_ENQUEUE: begin
                     if (is_full_now) begin
                        rsp_status_in = cfws_pkg::STS_FULL;
                     end else begin
                        chain_ctl.load = 1'b1;
                        count_in       = count_ff + cfws_pkg::cnt_type'(1);
                     end
                  end
                  cfws_pkg::ACT_DEQUEUE: begin
                     if (is_empty_now) begin
                        rsp_status_in = cfws_pkg::STS_EMPTY;
                     end else begin
                        // Advance the chain: the front wraps to the tail, out of range.
                        chain_ctl.shift = 1'b1;
                        rsp_data_in     = front_data;
                        count_in        = count_ff - cfws_pkg::cnt_type'(1);
                     end
                  end
                  cfws_pkg::ACT_SEARCH: begin
                     if (is_empty_now) begin
                        rsp_status_in = cfws_pkg::STS_EMPTY;
                     end else begin
                        // Hold the beat back; the scan emits the results.
                        rsp_valid_in = 1'b0;
                        key_in       = req_value;
                        state_in     = ST_COMPARE;
                     end
                  end
                  cfws_pkg::ACT_PEEK_FRONT: begin
                     if (is_empty_now) begin
                        rsp_status_in = cfws_pkg::STS_EMPTY;
                     end else begin
                        rsp_data_in = front_data;
                     end
                  end
                  cfws_pkg::ACT_PEEK_REAR: begin
                     if (is_empty_now) begin
                        rsp_status_in = cfws_pkg::STS_EMPTY;
                     end else begin
                        rsp_data_in = rear_data;
                     end
                  end
                  default: begin
                     // Unused codes: plain OK beat, nothing changes.
                  end
               endcase
            end
         end
         ST_COMPARE: begin
            // Tag every occupied cell that equals the key.
            chain_ctl.compare = 1'b1;
            step_in           = '0;
            state_in          = ST_SCAN;
         end
         ST_SCAN: begin
            // Rotate once per step; cell 0 holds the entry at position step+1.
            chain_ctl.shift = 1'b1;
            step_in         = step_ff + cfws_pkg::idx_type'(1);
            if (front_match) begin
               rsp_valid_in    = 1'b1;
               rsp_data_in     = key_ff;
               rsp_position_in = cfws_pkg::cnt_type'(step_ff) + cfws_pkg::cnt_type'(1);
               rsp_last_in     = !more_match;
            end else if ((step_ff == '0) && !any_match) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = cfws_pkg::STS_NOT_FOUND;
            end
            if (step_ff == LAST_STEP) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // A capacity write empties the FIFO; the user must write it only while idle, the block does not enforce this.
      if (csr_we) begin
         count_in = '0;
      end

      rsp_is_empty_in = (count_in == '0);
      rsp_is_full_in  = (count_in == cap_in);
   end

   always_ff @(posedge clock) begin
      key_ff          <= key_in;
      rsp_status_ff   <= rsp_status_in;
      rsp_data_ff     <= rsp_data_in;
      rsp_position_ff <= rsp_position_in;
      rsp_is_empty_ff <= rsp_is_empty_in;
      rsp_is_full_ff  <= rsp_is_full_in;
      rsp_last_ff     <= rsp_last_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         cap_ff       <= cfws_pkg::CAP_MAX;
         count_ff     <= '0;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cap_ff       <= cap_in;
         count_ff     <= count_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   cfws_chain u_chain (
      .clock         (clock),
      .reset         (reset),
      .ctl_i         (chain_ctl),
      .count_i       (count_ff),
      .word_i        (chain_word),
      .front_data_o  (front_data),
      .rear_data_o   (rear_data),
      .front_match_o (front_match),
      .more_match_o  (more_match),
      .any_match_o   (any_match)
   );

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_status   = rsp_status_ff;
   assign rsp_data     = rsp_data_ff;
   assign rsp_position = rsp_position_ff;
   assign rsp_is_empty = rsp_is_empty_ff;
   assign rsp_is_full  = rsp_is_full_ff;
   assign rsp_last     = rsp_last_ff;

   `CFWS_ASSERT_NEVER(a_count_over_cap, clock, reset, count_ff > cap_ff)
   `CFWS_ASSERT(a_compare_to_scan, clock, reset, (state_ff == ST_COMPARE) |=> ((state_ff == ST_SCAN) && (step_ff == '0)))
   `CFWS_ASSERT(a_scan_ends, clock, reset, ((state_ff == ST_SCAN) && (step_ff == LAST_STEP)) |=> (state_ff == ST_IDLE))
   `CFWS_ASSERT(a_not_found_beat, clock, reset, (rsp_valid && (rsp_status == cfws_pkg::STS_NOT_FOUND)) |-> (rsp_last && (rsp_position == '0)))

endmodule

// File: bench/fifo_search_checker.sv
`timescale 1ns / 1ps

module fifo_search_checker
   import cfws_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic               busy,
   input  logic [2:0]         req_action,
   input  logic signed [31:0] req_value,
   input  logic               rsp_valid,
   input  logic [1:0]         rsp_status,
   input  logic signed [31:0] rsp_data,
   input  logic [4:0]         rsp_position,
   input  logic               rsp_is_empty,
   input  logic               rsp_is_full,
   input  logic               rsp_last,
   input  logic               csr_we,
   input  logic [4:0]         csr_wdata,
   output int                 mismatch_count,
   output int                 owed_count
);

   typedef struct {
      status_type status;
      word_type   data;
      cnt_type    position;
      logic       is_empty;
      logic       is_full;
      logic       last;
   } beat_type;

   beat_type   owed_beats[$];
   beat_type   oldest_beat;
   word_type   ring_copy[DEPTH];
   idx_type    head_at;
   cnt_type    fill_level;
   logic [4:0] cap_setting;

   initial owed_count = 0;

   // Saturate the register into the usable ring size.
   function automatic cnt_type live_capacity();
      if (cap_setting < 5'd1) return cnt_type'(1);
      if (cap_setting > CAP_MAX) return CAP_MAX;
      return cap_setting;
   endfunction

   function automatic idx_type ring_offset(idx_type base, int unsigned step, cnt_type cap);
      return idx_type'((base + step) % cap);
   endfunction

   task automatic owe(status_type st, word_type d, cnt_type pos, logic fin);
      beat_type b;
      b.status   = st;
      b.data     = d;
      b.position = pos;
      b.is_empty = (fill_level == 0);
      b.is_full  = (fill_level == live_capacity());
      b.last     = fin;
      owed_beats.push_back(b);
   endtask

   task automatic apply_action(logic [2:0] act, word_type key);
      cnt_type cap;
      idx_type at;
      cnt_type hits[$];
      cap = live_capacity();
      if (head_at >= cap) head_at = '0;
      if (fill_level > cap) fill_level = cap;
      case (act)
         ACT_ENQUEUE: begin
            if (fill_level == cap) begin
               owe(STS_FULL, '0, '0, 1'b1);
            end else begin
               ring_copy[ring_offset(head_at, fill_level, cap)] = key;
               fill_level++;
               owe(STS_OK, '0, '0, 1'b1);
            end
         end
         ACT_DEQUEUE: begin
            if (fill_level == 0) begin
               owe(STS_EMPTY, '0, '0, 1'b1);
            end else begin
               at = head_at;
               head_at = ring_offset(head_at, 1, cap);
               fill_level--;
               owe(STS_OK, ring_copy[at], '0, 1'b1);
            end
         end
         ACT_SEARCH: begin
            if (fill_level == 0) begin
               owe(STS_EMPTY, '0, '0, 1'b1);
            end else begin
               for (int i = 0; i < fill_level; i++) begin
                  if (ring_copy[ring_offset(head_at, i, cap)] == key)
                     hits.push_back(cnt_type'(i + 1));
               end
               if (hits.size() == 0) begin
                  owe(STS_NOT_FOUND, '0, '0, 1'b1);
               end else begin
                  foreach (hits[k])
                     owe(STS_OK, key, hits[k], k == hits.size() - 1);
               end
            end
         end
         ACT_PEEK_FRONT: begin
            if (fill_level == 0) owe(STS_EMPTY, '0, '0, 1'b1);
            else owe(STS_OK, ring_copy[head_at], '0, 1'b1);
         end
         ACT_PEEK_REAR: begin
            if (fill_level == 0) owe(STS_EMPTY, '0, '0, 1'b1);
            else owe(STS_OK, ring_copy[ring_offset(head_at, fill_level - 1, cap)], '0, 1'b1);
         end
         default: begin
            owe(STS_OK, '0, '0, 1'b1);
         end
      endcase
   endtask

   always @(posedge clock) begin
      if (reset) begin
         owed_beats.delete();
         head_at        = '0;
         fill_level     = '0;
         cap_setting    = 5'd16;
         mismatch_count = 0;
      end else begin
         // Match the outgoing beat first: it belongs to an earlier item.
         if (rsp_valid) begin
            if (owed_beats.size() == 0) begin
               $error("unexpected result beat: status %0d data %0d position %0d",
                      rsp_status, rsp_data, rsp_position);
               mismatch_count++;
            end else begin
               oldest_beat = owed_beats.pop_front();
               if (rsp_status !== oldest_beat.status) begin
                  $error("status expected %0d actual %0d", oldest_beat.status, rsp_status);
                  mismatch_count++;
               end
               if (rsp_data !== oldest_beat.data) begin
                  $error("data expected %0d actual %0d", oldest_beat.data, rsp_data);
                  mismatch_count++;
               end
               if (rsp_position !== oldest_beat.position) begin
                  $error("position expected %0d actual %0d",
                         oldest_beat.position, rsp_position);
                  mismatch_count++;
               end
               if (rsp_is_empty !== oldest_beat.is_empty) begin
                  $error("is_empty expected %0d actual %0d",
                         oldest_beat.is_empty, rsp_is_empty);
                  mismatch_count++;
               end
               if (rsp_is_full !== oldest_beat.is_full) begin
                  $error("is_full expected %0d actual %0d", oldest_beat.is_full, rsp_is_full);
                  mismatch_count++;
               end
               if (rsp_last !== oldest_beat.last) begin
                  $error("last expected %0d actual %0d", oldest_beat.last, rsp_last);
                  mismatch_count++;
               end
            end
         end
         // A capacity write empties the ring but keeps the stored words.
         if (csr_we) begin
            cap_setting = csr_wdata;
            head_at     = '0;
            fill_level  = '0;
         end
         if (start && !busy) apply_action(req_action, req_value);
      end
      owed_count = owed_beats.size();
   end

endmodule

// File: bench/tb_circular_fifo_with_search.sv
`timescale 1ns / 1ps

module tb_circular_fifo_with_search;
   import cfws_pkg::*;

   // Longest correct stretch without any beat is a search rotation plus the
   // settle pause plus an idle burst; allow many times that.
   localparam int STALL_LIMIT   = 400;
   localparam int SETTLE_CYCLES = DEPTH + 4;
   localparam int RESET_CYCLES  = 11;
   localparam int PHASES        = 8;

   // Action codes the block ignores.
   localparam logic [2:0] ACT_SPARE_LO = 3'd5;
   localparam logic [2:0] ACT_SPARE_HI = 3'd7;

   localparam word_type WORD_MAX = 32'sh7fff_ffff;
   localparam word_type WORD_MIN = 32'sh8000_0000;

   // Capacity settings for the random phases: register extremes (0 and 31
   // saturate), the usable extremes 1 and 16, and a few sizes in between.
   localparam logic [4:0] CAP_PLAN [PHASES] =
      '{5'd0, 5'd31, 5'd5, 5'd1, 5'd16, 5'd9, 5'd3, 5'd16};

   logic               clock      = 1'b0;
   logic               reset      = 1'b1;
   logic               start      = 1'b0;
   logic               busy;
   logic [2:0]         req_action = '0;
   logic signed [31:0] req_value  = '0;
   logic               rsp_valid;
   logic [1:0]         rsp_status;
   logic signed [31:0] rsp_data;
   logic [4:0]         rsp_position;
   logic               rsp_is_empty;
   logic               rsp_is_full;
   logic               rsp_last;
   logic               csr_we     = 1'b0;
   logic [4:0]         csr_wdata  = '0;

   bit                 gaps_on    = 1'b1;
   int                 mismatch_count;
   int                 owed_count;

   always #10 clock = ~clock;

   circular_fifo_with_search u_dut (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_action   (req_action),
      .req_value    (req_value),
      .rsp_valid    (rsp_valid),
      .rsp_status   (rsp_status),
      .rsp_data     (rsp_data),
      .rsp_position (rsp_position),
      .rsp_is_empty (rsp_is_empty),
      .rsp_is_full  (rsp_is_full),
      .rsp_last     (rsp_last),
      .csr_we       (csr_we),
      .csr_wdata    (csr_wdata)
   );

   fifo_search_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_action     (req_action),
      .req_value      (req_value),
      .rsp_valid      (rsp_valid),
      .rsp_status     (rsp_status),
      .rsp_data       (rsp_data),
      .rsp_position   (rsp_position),
      .rsp_is_empty   (rsp_is_empty),
      .rsp_is_full    (rsp_is_full),
      .rsp_last       (rsp_last),
      .csr_we         (csr_we),
      .csr_wdata      (csr_wdata),
      .mismatch_count (mismatch_count),
      .owed_count     (owed_count)
   );

   // Half full-range noise, a quarter small words 0..3 so searches hit
   // repeatedly, and a quarter the two signed extremes.
   function automatic word_type pick_word();
      case ($urandom_range(0, 3))
         0, 1:    return word_type'($urandom);
         2:       return word_type'($urandom_range(0, 3));
         default: return ($urandom_range(0, 1) != 0) ? WORD_MAX : WORD_MIN;
      endcase
   endfunction

   // Lean on enqueue while filling so the ring reaches full and searches
   // see many entries; afterwards mix everything, spare codes included.
   function automatic logic [2:0] pick_action(bit filling);
      int roll;
      roll = $urandom_range(0, 99);
      if (filling) begin
         if (roll < 85) return ACT_ENQUEUE;
         if (roll < 95) return ACT_SEARCH;
         return ACT_PEEK_REAR;
      end
      if (roll < 30) return ACT_ENQUEUE;
      if (roll < 55) return ACT_DEQUEUE;
      if (roll < 80) return ACT_SEARCH;
      if (roll < 88) return ACT_PEEK_FRONT;
      if (roll < 96) return ACT_PEEK_REAR;
      return 3'($urandom_range(ACT_SPARE_LO, ACT_SPARE_HI));
   endfunction

   // Present one command beat and hold it until the block takes it. Keep
   // start high between back-to-back beats; drop it only for an idle burst.
   task automatic issue(logic [2:0] act, word_type val);
      if (gaps_on && $urandom_range(0, 3) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      start      <= 1'b1;
      req_action <= act;
      req_value  <= val;
      do @(posedge clock); while (busy);
   endtask

   // Drop start, wait for every owed beat and for the search rotation to
   // finish, then let the block sit idle a little before a register write.
   task automatic settle();
      start <= 1'b0;
      do @(posedge clock); while (owed_count != 0 || busy);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_capacity(logic [4:0] cap);
      csr_we    <= 1'b1;
      csr_wdata <= cap;
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   // Abort when nothing at all moves for too long.
   initial begin : watchdog
      int stall;
      stall = 0;
      while (stall < STALL_LIMIT) begin
         @(posedge clock);
         if ((start && !busy) || rsp_valid || csr_we) stall = 0;
         else stall++;
      end
      $display("simulation failed");
      $finish;
   end

   initial begin : stimulus
      int eff;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Reset capacity of 16: every action on an empty ring, ignored codes,
      // then duplicates and extremes so a search finds two matches.
      issue(ACT_DEQUEUE, 32'sd0);
      issue(ACT_SEARCH, 32'sd0);
      issue(ACT_PEEK_FRONT, 32'sd0);
      issue(ACT_PEEK_REAR, 32'sd0);
      issue(ACT_SPARE_LO, WORD_MAX);
      issue(ACT_SPARE_HI, WORD_MIN);
      issue(ACT_ENQUEUE, WORD_MIN);
      issue(ACT_ENQUEUE, WORD_MAX);
      issue(ACT_ENQUEUE, 32'sd0);
      issue(ACT_ENQUEUE, WORD_MAX);
      issue(ACT_ENQUEUE, -32'sd1);
      issue(ACT_SEARCH, WORD_MAX);
      issue(ACT_SEARCH, 32'sd12345);
      issue(ACT_PEEK_FRONT, 32'sd0);
      issue(ACT_PEEK_REAR, 32'sd0);
      issue(ACT_DEQUEUE, 32'sd0);

      // Capacity 2: the write empties the ring, enqueue refused when full,
      // then the rear wraps around to slot zero.
      settle();
      set_capacity(5'd2);
      issue(ACT_PEEK_FRONT, 32'sd0);
      issue(ACT_ENQUEUE, 32'sd1);
      issue(ACT_ENQUEUE, 32'sd2);
      issue(ACT_ENQUEUE, 32'sd3);
      issue(ACT_SEARCH, 32'sd2);
      issue(ACT_DEQUEUE, 32'sd0);
      issue(ACT_ENQUEUE, 32'sd4);
      issue(ACT_PEEK_REAR, 32'sd0);
      issue(ACT_SEARCH, 32'sd4);

      // Random phases, one per capacity setting; the last runs without gaps.
      for (int p = 0; p < PHASES; p++) begin
         settle();
         set_capacity(CAP_PLAN[p]);
         eff = (CAP_PLAN[p] < 5'd1) ? 1 : (CAP_PLAN[p] > CAP_MAX) ? CAP_MAX : CAP_PLAN[p];
         if (p == PHASES - 1) gaps_on = 1'b0;
         for (int k = 0; k < eff + 12; k++)
            issue(pick_action(k < eff + 2), pick_word());
      end
      start <= 1'b0;

      // Wait out every owed beat, then the tail of any search rotation.
      do @(posedge clock); while (owed_count != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && owed_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

// File: circular_fifo_with_search.f
+incdir+rtl
rtl/cfws_pkg.sv
rtl/cfws_cell.sv
rtl/cfws_chain.sv
rtl/circular_fifo_with_search.sv
bench/fifo_search_checker.sv
bench/tb_circular_fifo_with_search.sv
